// File: sv/bmpe_pkg.sv
//------------------------------------------------------------------------------
// bmpe_pkg
// Shared types, constants and the BMP header byte lookup for the encoder.
//------------------------------------------------------------------------------
package bmpe_pkg;

	localparam int DIM_BITS  = 12;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);
	localparam int HIDX_W    = 6;
	localparam int HDR_LAST  = 53;
	localparam int ADDR_W    = 3;

	localparam logic [7:0]  SIG_B     = 8'h42;
	localparam logic [7:0]  SIG_M     = 8'h4D;
	localparam logic [31:0] HDR_SIZE  = 32'd54;
	localparam logic [31:0] INFO_SIZE = 32'd40;
	localparam logic [15:0] PLANES    = 16'd1;
	localparam logic [15:0] BPP       = 16'd24;

	typedef enum logic {
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_PIX,
		ST_PAD
	} bk_state_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       hdr;
		logic [1:0] pad;
		logic       done;
	} pix_cmd_t;

	typedef struct packed {
		logic [QCNT_W-1:0] level;
		logic              full;
		logic              nonempty;
	} q_stat_t;

	typedef struct packed {
		logic busy;
	} bk_stat_t;

	// Byte idx of the 54-byte header; after 'BM' the fields form 32-bit words.
	function automatic logic [7:0] header_byte(
		input logic [HIDX_W-1:0] idx,
		input logic [31:0]       w32,
		input logic [31:0]       h32,
		input logic [31:0]       img,
		input logic [31:0]       fsz
	);
		logic [HIDX_W-1:0] off;
		logic [31:0]       word;
		logic [7:0]        b;
		off = idx - HIDX_W'(2);
		case (off[5:2])
			4'd0:    word = fsz;
			4'd2:    word = HDR_SIZE;
			4'd3:    word = INFO_SIZE;
			4'd4:    word = w32;
			4'd5:    word = h32;
			4'd6:    word = {BPP, PLANES};
			4'd8:    word = img;
			default: word = 32'd0;
		endcase
		b = 8'(word >> {off[1:0], 3'b000});
		if (idx == HIDX_W'(0))
			b = SIG_B;
		else if (idx == HIDX_W'(1))
			b = SIG_M;
		return b;
	endfunction

endpackage

// File: sv/bmpe_front.sv
//------------------------------------------------------------------------------
// bmpe_front
// Accepts pixels, tracks column and row, and classifies each pixel item.
//------------------------------------------------------------------------------
module bmpe_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [7:0]               red,
	input  logic [7:0]               green,
	input  logic [7:0]               blue,
	input  logic [bmpe_pkg::DIM_BITS-1:0] image_width,
	input  logic [bmpe_pkg::DIM_BITS-1:0] image_height,
	input  bmpe_pkg::q_stat_t        q_stat,
	output logic                     cmd_push,
	output bmpe_pkg::pix_cmd_t       cmd
);
	import bmpe_pkg::*;

	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] row_q;
	logic [DIM_BITS:0]   next_col;
	logic [DIM_BITS:0]   next_row;
	logic                row_end;
	logic                img_done;
	logic                accept;

	assign full     = q_stat.full;
	assign accept   = push && !q_stat.full;
	assign cmd_push = accept;

	assign next_col = (DIM_BITS+1)'(col_q) + 1'b1;
	assign next_row = (DIM_BITS+1)'(row_q) + 1'b1;
	assign row_end  = next_col >= (DIM_BITS+1)'(image_width);
	assign img_done = row_end && (next_row >= (DIM_BITS+1)'(image_height));

	always_comb begin
		cmd.red   = red;
		cmd.green = green;
		cmd.blue  = blue;
		cmd.hdr   = (col_q == '0) && (row_q == '0);
		cmd.pad   = row_end ? image_width[1:0] : 2'd0;
		cmd.done  = img_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (img_done)
					row_q <= '0;
				else
					row_q <= next_row[DIM_BITS-1:0];
			end else begin
				col_q <= next_col[DIM_BITS-1:0];
			end
		end
	end

endmodule

// File: sv/bmpe_queue.sv
//------------------------------------------------------------------------------
// bmpe_queue
// Short queue of classified pixel items between front and back end.
//------------------------------------------------------------------------------
module bmpe_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bmpe_pkg::pix_cmd_t cmd_in,
	input  logic               pop,
	output bmpe_pkg::pix_cmd_t cmd_out,
	output bmpe_pkg::q_stat_t  stat
);
	import bmpe_pkg::*;

	pix_cmd_t          entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] level_q;
	logic              do_push;
	logic              do_pop;

	assign stat.level    = level_q;
	assign stat.full     = level_q == QCNT_W'(QDEPTH);
	assign stat.nonempty = level_q != '0;
	assign do_push       = push && !stat.full;
	assign do_pop        = pop && stat.nonempty;
	assign cmd_out       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= cmd_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				level_q <= level_q + 1'b1;
			else if (do_pop && !do_push)
				level_q <= level_q - 1'b1;
		end
	end

endmodule

// File: sv/bmpe_back.sv
//------------------------------------------------------------------------------
// bmpe_back
// Byte sequencer: header, blue/green/red and row padding into the output item.
//------------------------------------------------------------------------------
module bmpe_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bmpe_pkg::q_stat_t             q_stat,
	input  bmpe_pkg::pix_cmd_t            q_cmd,
	output logic                          q_pop,
	input  logic [bmpe_pkg::DIM_BITS-1:0] image_width,
	input  logic [bmpe_pkg::DIM_BITS-1:0] image_height,
	input  logic [31:0]                   img_size,
	input  logic [31:0]                   file_size,
	output bmpe_pkg::bk_stat_t            stat,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          run_last,
	output logic                          file_end
);
	import bmpe_pkg::*;

	bk_state_t         st_q, st_d;
	logic [HIDX_W-1:0] idx_q, idx_d;
	pix_cmd_t          cur_q, cur_d;
	logic              out_adv;
	logic              emit;
	logic [7:0]        byte_d;
	logic              last_d;
	logic              outv_q;
	logic [7:0]        obyte_q;
	logic              olast_q;
	logic              oend_q;

	assign out_adv = !outv_q || pop;
	assign emit    = (st_q != ST_IDLE) && out_adv;

	// byte selection
	always_comb begin
		byte_d = 8'd0;
		last_d = 1'b0;
		case (st_q)
			ST_HDR: begin
				byte_d = header_byte(idx_q, 32'(image_width), 32'(image_height),
					img_size, file_size);
			end
			ST_PIX: begin
				case (idx_q[1:0])
					2'd0:    byte_d = cur_q.blue;
					2'd1:    byte_d = cur_q.green;
					default: byte_d = cur_q.red;
				endcase
				last_d = (idx_q[1:0] == 2'd2) && (cur_q.pad == 2'd0);
			end
			ST_PAD: begin
				last_d = (idx_q[1:0] + 2'd1) == cur_q.pad;
			end
			default: begin
				byte_d = 8'd0;
			end
		endcase
	end

	// next state
	always_comb begin
		st_d  = st_q;
		idx_d = idx_q;
		cur_d = cur_q;
		q_pop = 1'b0;
		if (st_q == ST_IDLE || (out_adv && last_d)) begin
			if (q_stat.nonempty) begin
				q_pop = 1'b1;
				cur_d = q_cmd;
				idx_d = '0;
				st_d  = q_cmd.hdr ? ST_HDR : ST_PIX;
			end else begin
				st_d = ST_IDLE;
			end
		end else if (out_adv) begin
			case (st_q)
				ST_HDR: begin
					if (idx_q == HIDX_W'(HDR_LAST)) begin
						st_d  = ST_PIX;
						idx_d = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				ST_PIX: begin
					if (idx_q[1:0] == 2'd2) begin
						st_d  = ST_PAD;
						idx_d = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
				default: begin
					idx_d = idx_q + 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			idx_q  <= '0;
			outv_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
			if (emit)
				outv_q <= 1'b1;
			else if (pop)
				outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (emit) begin
			obyte_q <= byte_d;
			olast_q <= last_d;
			oend_q  <= last_d && cur_q.done;
		end
	end

	assign stat.busy       = st_q != ST_IDLE;
	assign empty           = !outv_q;
	assign out_byte        = obyte_q;
	assign run_last        = olast_q;
	assign file_end        = oend_q;

endmodule

// File: sv/bmp24_stream_encoder.sv
//------------------------------------------------------------------------------
// bmp24_stream_encoder
// RGB pixel stream in, 24-bit BMP file byte stream out.
//------------------------------------------------------------------------------
// Pixels go in row-major order and come out one byte per cycle as blue, green,
// red, while the receiver keeps popping. The first pixel of each image is
// preceded by the 54-byte header, and the last pixel of a row is followed by
// image_width mod 4 zero pad bytes. Bytes pass through the byte-wide output
// register of the back-end sequencer, which waits in idle for a queued pixel.
// Pixels are taken one per cycle into a four-entry queue while it has room.
// Set image_width and image_height only while no pixel is in flight.
module bmp24_stream_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bmpe_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    out_byte,
	output logic                          run_last,
	output logic                          file_end
);
	import bmpe_pkg::*;

	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [31:0]         img_q;
	logic [31:0]         fsz;
	logic [31:0]         row_bytes;
	logic                cfg_wr;
	reg_idx_t            reg_sel;
	q_stat_t             q_stat;
	bk_stat_t            bk_stat;
	pix_cmd_t            f_cmd;
	pix_cmd_t            q_cmd;
	logic                f_push;
	logic                q_pop;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_BITS'(1);
			height_q <= DIM_BITS'(1);
		end else if (cfg_wr) begin
			if (reg_sel == REG_IMAGE_WIDTH)
				width_q <= pwdata[DIM_BITS-1:0];
			else
				height_q <= pwdata[DIM_BITS-1:0];
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IMAGE_WIDTH: prdata = 32'(width_q);
			default:         prdata = 32'(height_q);
		endcase
	end

	// rows are 3*width rounded up to a multiple of four
	assign row_bytes = (32'(width_q) * 32'd3 + 32'd3) & ~32'd3;

	always_ff @(posedge clk) begin
		img_q <= row_bytes * 32'(height_q);
	end

	assign fsz = img_q + HDR_SIZE;

	bmpe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.image_width  (width_q),
		.image_height (height_q),
		.q_stat       (q_stat),
		.cmd_push     (f_push),
		.cmd          (f_cmd)
	);

	bmpe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.cmd_in  (f_cmd),
		.pop     (q_pop),
		.cmd_out (q_cmd),
		.stat    (q_stat)
	);

	bmpe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop),
		.image_width  (width_q),
		.image_height (height_q),
		.img_size     (img_q),
		.file_size    (fsz),
		.stat         (bk_stat),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.file_end     (file_end)
	);

`ifndef SYNTH
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && file_end) |-> run_last)
		else $error("file_end without run_last");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= QCNT_W'(QDEPTH))
		else $error("pixel queue overflow");

	a_back_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(!bk_stat.busy && q_stat.nonempty) |=> bk_stat.busy)
		else $error("back end idle with queued pixels");
`endif

endmodule

// File: sim/tb_bmp24_stream_encoder.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_bmp24_stream_encoder
// Self-checking testbench for the 24-bit BMP stream encoder.
//------------------------------------------------------------------------------
// Pixels are pushed in through the input queue port. A local model of the
// encoder predicts every file byte that each pixel causes: the header, the
// BGR bytes, the row padding, and the run_last and file_end marks. A checker
// compares each popped byte with the oldest prediction. Image sizes are set
// over the APB port after the output drains and read back after each write.
// The traffic phases mix sender idling and receiver stalls. In one phase the
// receiver holds off long enough for the input side to fill up.
//------------------------------------------------------------------------------
module tb_bmp24_stream_encoder;
	import bmpe_pkg::*;

	localparam int RESET_CYCLES   = 5;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 80;
	localparam int TIMEOUT_NS     = 4_000_000;
	localparam int MAX_REPORTS    = 10;
	localparam int HEADER_LEN     = 54;
	localparam int INFO_LEN       = 40;
	localparam int BITS_PER_PIXEL = 24;
	localparam int COLOR_PLANES   = 1;
	localparam logic [31:0] DIM_MASK = (32'd1 << DIM_BITS) - 32'd1;

	typedef struct packed {
		logic [7:0] value;
		logic       run_last;
		logic       file_end;
	} file_byte_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              push    = 1'b0;
	logic              full;
	logic [7:0]        red     = '0;
	logic [7:0]        green   = '0;
	logic [7:0]        blue    = '0;
	logic              empty;
	logic              pop     = 1'b0;
	logic [7:0]        out_byte;
	logic              run_last;
	logic              file_end;

	// encoder model state, reset values
	int unsigned img_width  = 1;
	int unsigned img_height = 1;
	int unsigned col_pos    = 0;
	int unsigned row_pos    = 0;

	file_byte_t file_bytes_due[$];

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic recv_hold      = 1'b0;
	event hold_start;

	int mismatch_count = 0;
	int pixels_taken   = 0;
	int bytes_checked  = 0;
	int files_closed   = 0;

	bmp24_stream_encoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.push     (push),
		.full     (full),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.run_last (run_last),
		.file_end (file_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	function automatic void expect_byte(input logic [7:0] value);
		file_byte_t fb;
		fb.value    = value;
		fb.run_last = 1'b0;
		fb.file_end = 1'b0;
		file_bytes_due.push_back(fb);
	endfunction

	function automatic void expect_le(input logic [31:0] value, input int nbytes);
		for (int k = 0; k < nbytes; k++)
			expect_byte(value[8*k +: 8]);
	endfunction

	function automatic int unsigned padded_row_len();
		return (img_width * 3 + 3) & ~32'd3;
	endfunction

	function automatic void expect_header();
		int unsigned data_len;
		data_len = padded_row_len() * img_height;
		expect_byte("B");
		expect_byte("M");
		expect_le(data_len + HEADER_LEN, 4);
		expect_le(0, 4);
		expect_le(HEADER_LEN, 4);
		expect_le(INFO_LEN, 4);
		expect_le(img_width, 4);
		expect_le(img_height, 4);
		expect_le(COLOR_PLANES, 2);
		expect_le(BITS_PER_PIXEL, 2);
		expect_le(0, 4);
		expect_le(data_len, 4);
		repeat (4) expect_le(0, 4);
	endfunction

	function automatic void predict_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned next_col;
		int unsigned next_row;
		int unsigned pad;
		logic        image_done;
		image_done = 1'b0;
		if (col_pos == 0 && row_pos == 0)
			expect_header();
		expect_byte(b);
		expect_byte(g);
		expect_byte(r);
		next_col = col_pos + 1;
		if (next_col >= img_width) begin
			pad = padded_row_len() - img_width * 3;
			repeat (pad) expect_byte(8'h00);
			col_pos  = 0;
			next_row = row_pos + 1;
			if (next_row >= img_height) begin
				row_pos    = 0;
				image_done = 1'b1;
			end else begin
				row_pos = next_row;
			end
		end else begin
			col_pos = next_col;
		end
		file_bytes_due[file_bytes_due.size() - 1].run_last = 1'b1;
		file_bytes_due[file_bytes_due.size() - 1].file_end = image_done;
	endfunction

	function automatic logic [23:0] random_pixel();
		case ($urandom_range(9))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			default: return 24'($urandom);
		endcase
	endfunction

	// byte checker and receiver side
	always @(posedge clk) begin
		file_byte_t want;
		if (pop && !empty) begin
			if (file_bytes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected byte %0h", $time, out_byte);
			end else begin
				want = file_bytes_due.pop_front();
				check_field("out_byte", 32'(want.value), 32'(out_byte));
				check_field("run_last", 32'(want.run_last), 32'(run_last));
				check_field("file_end", 32'(want.file_end), 32'(file_end));
				bytes_checked++;
				if (want.file_end)
					files_closed++;
			end
		end
		pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off
	initial begin
		forever begin
			@(hold_start);
			recv_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout, %0d bytes still due", $time, file_bytes_due.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_pixel(input logic [23:0] rgb);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push  <= 1'b1;
		red   <= rgb[23:16];
		green <= rgb[15:8];
		blue  <= rgb[7:0];
		do @(posedge clk); while (full);
		predict_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
		pixels_taken++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (file_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_IMAGE_WIDTH)
			img_width = value & DIM_MASK;
		else
			img_height = value & DIM_MASK;
		// back-to-back read of the same register
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field($sformatf("%s readback", idx.name()), value & DIM_MASK, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
	endtask

	task automatic test_row_padding();
		write_reg(REG_IMAGE_HEIGHT, 32'd1);
		for (int w = 1; w <= 4; w++) begin
			write_reg(REG_IMAGE_WIDTH, 32'(w));
			repeat (w) send_pixel(random_pixel());
		end
	endtask

	task automatic test_register_masking();
		write_reg(REG_IMAGE_WIDTH, 32'hFFFF_F002);
		write_reg(REG_IMAGE_HEIGHT, 32'hA5A5_A001);
		send_pixel(24'h0F0F0F);
		send_pixel(24'hF0F0F0);
	endtask

	task automatic test_zero_dims();
		write_reg(REG_IMAGE_WIDTH, 32'hFFFF_F000);
		write_reg(REG_IMAGE_HEIGHT, 32'h0000_1000);
		send_pixel(24'h000000);
		send_pixel(24'hFFFFFF);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		send_pixel(24'h5A5A5A);
		send_pixel(24'hA5A5A5);
	endtask

	task automatic test_resize_mid_image();
		write_reg(REG_IMAGE_WIDTH, DIM_MASK);
		write_reg(REG_IMAGE_HEIGHT, DIM_MASK);
		repeat (3) send_pixel(random_pixel());
		// shrink below the current column: row and image end on the next pixel
		write_reg(REG_IMAGE_WIDTH, 32'd2);
		write_reg(REG_IMAGE_HEIGHT, 32'd1);
		send_pixel(random_pixel());
		send_pixel(random_pixel());
	endtask

	task automatic test_backpressure();
		write_reg(REG_IMAGE_WIDTH, 32'd3);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		-> hold_start;
		repeat (16) send_pixel(random_pixel());
		drain();
		repeat (4) send_pixel(random_pixel());
		drain();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int count);
		int unsigned sel;
		int unsigned w;
		int unsigned h;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			if (i == 0 || i == count / 2) begin
				sel = $urandom_range(99);
				if (sel < 5)
					w = 0;
				else if (sel < 10)
					w = $urandom_range(DIM_MASK);
				else if (sel < 85)
					w = $urandom_range(6, 1);
				else
					w = $urandom_range(20, 7);
				sel = $urandom_range(99);
				if (sel < 5)
					h = 0;
				else if (sel < 10)
					h = $urandom_range(DIM_MASK);
				else
					h = $urandom_range(3, 1);
				write_reg(REG_IMAGE_WIDTH, {20'($urandom), 12'(w)});
				write_reg(REG_IMAGE_HEIGHT, {20'($urandom), 12'(h)});
			end
			send_pixel(random_pixel());
		end
		drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_row_padding();
		test_register_masking();
		test_zero_dims();
		test_resize_mid_image();
		test_backpressure();
		test_random_traffic(0, 0, 50);
		test_random_traffic(70, 0, 50);
		test_random_traffic(0, 70, 50);
		test_random_traffic(22, 22, 50);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d bytes from %0d pixels, %0d complete files.",
			bytes_checked, pixels_taken, files_closed);
		$display("Covered padding, zero and full-scale sizes, masking, resizing, stalls.");
		if (mismatch_count == 0 && file_bytes_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
sv/bmpe_pkg.sv
sv/bmpe_front.sv
sv/bmpe_queue.sv
sv/bmpe_back.sv
sv/bmp24_stream_encoder.sv
sim/tb_bmp24_stream_encoder.sv
